@@ hw/rtl/tod_pkg.sv @@
// tod_pkg: shared widths, constants and types for the tilt-to-octant block.
// No dependencies.
package tod_pkg;

  localparam int ONE_G      = 16384;
  localparam int TILT_W     = 16;
  localparam int MAG_W      = 15;
  localparam int SEC_W      = 3;
  localparam int DZ_W       = 15;
  localparam int DZ_RESET   = 3277;

  // APB side: one 32-bit register, paddr[2] selects the register slot
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_DEADZONE = 1'b0;

  // Square root: 28-bit radicand, 14-bit root, two digits per stage
  localparam int SQ_IN_W    = 28;
  localparam int SQ_ROOT_W  = SQ_IN_W / 2;
  localparam int SQ_REM_W   = SQ_ROOT_W + 1;
  localparam int SQ_PER_STG = 2;
  localparam int SQ_STAGES  = SQ_ROOT_W / SQ_PER_STG;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_t;

  // Sideband carried down the root pipeline
  typedef struct packed {
    logic             sat;
    logic             act;
    logic [SEC_W-1:0] sec;
  } side_t;

endpackage

@@ hw/rtl/tod_ifs.sv @@
// tod_ifs: valid/ready channel interfaces for tilt samples and drive beats.
// Depends on tod_pkg.
interface tod_tilt_if import tod_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TILT_W-1:0] tilt_x;
  logic signed [TILT_W-1:0] tilt_y;

  modport source (output valid, tilt_x, tilt_y, input ready);
  modport sink   (input valid, tilt_x, tilt_y, output ready);
endinterface

interface tod_drive_if import tod_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEC_W-1:0] sector;
  logic [MAG_W-1:0] magnitude;
  logic             active;

  modport source (output valid, sector, magnitude, active, input ready);
  modport sink   (input valid, sector, magnitude, active, output ready);
endinterface

@@ hw/rtl/tilt_to_octant_drive_direction.sv @@
// Tilt-to-octant drive direction: a registered pipeline from tilt beat to drive beat.
// Throughput one beat per cycle while drive is ready; each stage has its own valid and
// advances when empty or when the stage after it advances, so bubbles collapse under stall.
// Depth is set by the square root: 14 digits, two per stage, seven stages.
// Reset (rst, sync, active high) empties the pipe and loads deadzone = 3277.
// Depends on tod_pkg and tod_ifs.
module tilt_to_octant_drive_direction import tod_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tod_tilt_if.sink              tilt,
  tod_drive_if.source           drive,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Stage map: 0 clamp/abs, 1 products, 2 sums, 3 compares/sector,
  // 4.. root digits.
  localparam int NSTG = 4 + SQ_STAGES;
  localparam int LAST = NSTG - 1;

  // ---------------------------------------------------------------
  // Config register. dz2 follows deadzone in the next cycle; writes must only
  // happen while idle (not enforced by the block), so a sample never sees the lag.
  // ---------------------------------------------------------------
  logic [DZ_W-1:0]   deadzone;
  logic [2*DZ_W-1:0] dz2;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= DZ_W'(DZ_RESET);
      dz2      <= (2*DZ_W)'(DZ_RESET * DZ_RESET);
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_DEADZONE) begin
        deadzone <= pwdata[DZ_W-1:0];
      end
      dz2 <= (2*DZ_W)'(deadzone) * (2*DZ_W)'(deadzone);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DEADZONE) begin
      prdata = APB_DATA_W'(deadzone);
    end
  end

  // ---------------------------------------------------------------
  // Per-stage valid and advance. A stage loads when it is empty or
  // its contents move on in the same cycle.
  // ---------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[LAST] = !vld[LAST] || drive.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign tilt.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= tilt.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 0: u = Y, v = -X, clamp to +/-1 g, split into sign and size.
  // ---------------------------------------------------------------
  logic signed [TILT_W:0] u_w, v_w, u_c, v_c;
  logic [MAG_W-1:0]       s0_a, s0_b;
  logic                   s0_uneg, s0_vneg;

  always_comb begin
    u_w = (TILT_W+1)'(tilt.tilt_y);
    v_w = -((TILT_W+1)'(tilt.tilt_x));
    if (u_w > ONE_G) begin
      u_c = (TILT_W+1)'(ONE_G);
    end else if (u_w < -ONE_G) begin
      u_c = -((TILT_W+1)'(ONE_G));
    end else begin
      u_c = u_w;
    end
    if (v_w > ONE_G) begin
      v_c = (TILT_W+1)'(ONE_G);
    end else if (v_w < -ONE_G) begin
      v_c = -((TILT_W+1)'(ONE_G));
    end else begin
      v_c = v_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_uneg <= u_c[TILT_W];
      s0_vneg <= v_c[TILT_W];
      s0_a    <= u_c[TILT_W] ? MAG_W'(-u_c) : MAG_W'(u_c);
      s0_b    <= v_c[TILT_W] ? MAG_W'(-v_c) : MAG_W'(v_c);
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: a*a, b*b, a*b (15x15 each, side by side).
  // ---------------------------------------------------------------
  logic [2*MAG_W-1:0] s1_aa, s1_bb, s1_ab;
  logic               s1_uneg, s1_vneg;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_aa   <= (2*MAG_W)'(s0_a) * (2*MAG_W)'(s0_a);
      s1_bb   <= (2*MAG_W)'(s0_b) * (2*MAG_W)'(s0_b);
      s1_ab   <= (2*MAG_W)'(s0_a) * (2*MAG_W)'(s0_b);
      s1_uneg <= s0_uneg;
      s1_vneg <= s0_vneg;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: len2 = a^2 + b^2 and (a+b)^2 = len2 + 2ab.
  // ---------------------------------------------------------------
  logic [2*MAG_W-1:0] s2_aa, s2_bb, s2_len2;
  logic [2*MAG_W:0]   s2_s;
  logic               s2_uneg, s2_vneg;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_len2 <= s1_aa + s1_bb;
      s2_s    <= (2*MAG_W+1)'(s1_aa) + (2*MAG_W+1)'(s1_bb) + {s1_ab, 1'b0};
      s2_aa   <= s1_aa;
      s2_bb   <= s1_bb;
      s2_uneg <= s1_uneg;
      s2_vneg <= s1_vneg;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: octant from exact square compares against the 22.5 and
  // 67.5 degree lines, saturation, deadzone test.
  // (a+b)^2 <= 2a^2 : at or past 67.5 deg from +v (zone 2)
  // (a+b)^2 >= 2b^2 : at or past 22.5 deg (zone 1)
  // ---------------------------------------------------------------
  logic [1:0]         zone;
  logic [SEC_W-1:0]   sec_raw;
  logic               sat_w, act_w;
  side_t              s3_side;
  logic [SQ_IN_W-1:0] s3_n;

  always_comb begin
    if (s2_s <= {s2_aa, 1'b0}) begin
      zone = 2'd2;
    end else if (s2_s >= {s2_bb, 1'b0}) begin
      zone = 2'd1;
    end else begin
      zone = 2'd0;
    end
    case ({s2_vneg, s2_uneg})
      2'b00:   sec_raw = SEC_W'(zone);
      2'b01:   sec_raw = SEC_W'(3'd0 - SEC_W'(zone));
      2'b10:   sec_raw = SEC_W'(3'd4 - SEC_W'(zone));
      2'b11:   sec_raw = SEC_W'(3'd4 + SEC_W'(zone));
      default: sec_raw = '0;
    endcase
    sat_w = s2_len2 >= (2*MAG_W)'(ONE_G * ONE_G);
    act_w = sat_w ? (deadzone <= DZ_W'(ONE_G)) : (s2_len2 >= dz2);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_side.sat <= sat_w;
      s3_side.act <= act_w;
      // inactive or zero vector: sector 0
      s3_side.sec <= (act_w && s2_len2 != '0) ? sec_raw : '0;
      s3_n        <= s2_len2[SQ_IN_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Stages 4..: restoring square root, two digits per stage.
  // ---------------------------------------------------------------
  function automatic sq_t sq_step(sq_t cur, logic [1:0] pair);
    logic [SQ_REM_W+1:0] rem_t;
    logic [SQ_REM_W+1:0] trial;
    sq_t                 nxt;
    rem_t = {cur.rem, pair};
    trial = (SQ_REM_W+2)'({cur.root, 2'b01});
    if (rem_t >= trial) begin
      nxt.rem  = SQ_REM_W'(rem_t - trial);
      nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rem_t[SQ_REM_W-1:0];
      nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  sq_t                q_st   [SQ_STAGES];
  logic [SQ_IN_W-1:0] q_n    [SQ_STAGES];
  side_t              q_side [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    sq_t                st_in, st_out;
    logic [SQ_IN_W-1:0] n_in, n_out;
    side_t              side_in;

    if (k == 0) begin : g_first
      assign st_in   = '0;
      assign n_in    = s3_n;
      assign side_in = s3_side;
    end else begin : g_next
      assign st_in   = q_st[k-1];
      assign n_in    = q_n[k-1];
      assign side_in = q_side[k-1];
    end

    always_comb begin
      st_out = st_in;
      n_out  = n_in;
      for (int j = 0; j < SQ_PER_STG; j++) begin
        st_out = sq_step(st_out, n_out[SQ_IN_W-1 -: 2]);
        n_out  = {n_out[SQ_IN_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (en[4+k]) begin
        q_st[k]   <= st_out;
        q_n[k]    <= n_out;
        q_side[k] <= side_in;
      end
    end
  end

  // ---------------------------------------------------------------
  // Drive beat straight from the last root stage.
  // ---------------------------------------------------------------
  side_t last_side;
  assign last_side = q_side[SQ_STAGES-1];

  assign drive.valid  = vld[LAST];
  assign drive.active = last_side.act;
  assign drive.sector = last_side.sec;

  always_comb begin
    if (!last_side.act) begin
      drive.magnitude = '0;
    end else if (last_side.sat) begin
      drive.magnitude = MAG_W'(ONE_G);
    end else begin
      drive.magnitude = MAG_W'(q_st[SQ_STAGES-1].root);
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    drive.valid && !drive.active |-> drive.magnitude == '0 && drive.sector == '0)
    else $error("inactive beat carries direction or magnitude");

  a_mag_cap: assert property (@(posedge clk) disable iff (rst)
    drive.valid |-> drive.magnitude <= MAG_W'(ONE_G))
    else $error("magnitude above 1.0");

  a_dz_sq: assert property (@(posedge clk) disable iff (rst)
    dz2 == (2*DZ_W)'($past(deadzone)) * (2*DZ_W)'($past(deadzone)))
    else $error("deadzone square out of step with register");

  a_take: assert property (@(posedge clk) disable iff (rst)
    tilt.valid && tilt.ready |=> vld[0])
    else $error("accepted sample not captured in first stage");

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for the tilt-to-octant drive direction block.
// Random valid/ready pacing on both channels, APB deadzone writes between phases.
// Depends on tod_pkg, tod_ifs and tilt_to_octant_drive_direction.
module tb import tod_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog: cycles without any beat before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  localparam int SHOWN_MAX  = 10;
  // Register 0 sits at byte address 0
  localparam logic [APB_ADDR_W-1:0] DEADZONE_ADDR = {REG_DEADZONE, 2'b00};
  localparam longint unsigned FULL_LEN2 = ONE_G * ONE_G;

  typedef struct packed {
    logic signed [TILT_W-1:0] x;
    logic signed [TILT_W-1:0] y;
  } tilt_sample_t;

  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [MAG_W-1:0] magnitude;
    logic             active;
  } drive_beat_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tod_tilt_if  tilt_ch ();
  tod_drive_if drive_ch ();

  tilt_to_octant_drive_direction i_dut (
    .clk     (clk),
    .rst     (rst),
    .tilt    (tilt_ch),
    .drive   (drive_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bench copy of the deadzone register, updated right after each APB write
  logic [DZ_W-1:0] dz_cfg = DZ_W'(DZ_RESET);

  tilt_sample_t tilt_backlog[$];   // samples waiting for the driver
  drive_beat_t  drive_due[$];      // predicted drive beats, oldest first

  int n_queued    = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int n_active    = 0;
  int n_settings  = 1;
  int mismatches  = 0;
  int idle_cycles = 0;
  logic [7:0] sectors_seen = '0;

  // Set at the edge where a beat moved; read by the pacing blocks on the next fall
  logic tilt_took  = 1'b0;
  logic drive_took = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic int clamp_one_g(input int val);
    if (val > ONE_G) return ONE_G;
    if (val < -ONE_G) return -ONE_G;
    return val;
  endfunction

  // Direction vector is (fwd_y, side) = (Y, -X), angle measured from +side toward
  // +fwd_y. Sector boundaries at 22.5 and 67.5 degrees within a quadrant are
  // tested with integer squares: (a+b)^2 vs 2a^2 and 2b^2.
  function automatic drive_beat_t drive_from_tilt(input logic signed [TILT_W-1:0] tx,
                                                  input logic signed [TILT_W-1:0] ty,
                                                  input logic [DZ_W-1:0] dz);
    int              fwd, side, zone, sec;
    longint unsigned a, b, len2, s, root, trial, dz2;
    logic            act;
    drive_beat_t     r;
    fwd  = clamp_one_g(int'(ty));
    side = clamp_one_g(-int'(tx));
    a    = 64'((fwd < 0) ? -fwd : fwd);
    b    = 64'((side < 0) ? -side : side);
    len2 = a * a + b * b;
    dz2  = 64'(dz);
    dz2  = dz2 * dz2;
    root = 0;
    if (len2 >= FULL_LEN2) begin
      // saturated length; a deadzone above 1.0 can never be reached
      root = 64'(ONE_G);
      act  = (dz <= ONE_G);
    end else begin
      for (int k = MAG_W - 1; k >= 0; k--) begin
        trial = root | (64'd1 << k);
        if (trial * trial <= len2) root = trial;
      end
      act = (len2 >= dz2);
    end
    sec = 0;
    if (act && len2 != 0) begin
      s = (a + b) * (a + b);
      if (s <= 2 * a * a) zone = 2;
      else if (s >= 2 * b * b) zone = 1;
      else zone = 0;
      if (side < 0) sec = (fwd < 0) ? 4 + zone : 4 - zone;
      else sec = (fwd < 0) ? (8 - zone) % 8 : zone;
    end
    r.sector    = act ? SEC_W'(sec) : '0;
    r.magnitude = act ? MAG_W'(root) : '0;
    r.active    = act;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic logic signed [TILT_W-1:0] sat16(input int val);
    if (val > 32767) return 16'sh7fff;
    if (val < -32768) return 16'sh8000;
    return TILT_W'(val);
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mix: raw 16-bit noise, uniform within +/-1 g, points hugging a sector
  // boundary, points hugging the deadzone radius, points hugging full scale.
  function automatic tilt_sample_t random_tilt(input logic [DZ_W-1:0] dz);
    tilt_sample_t smp;
    int           pick, m, n, r;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      smp.x = TILT_W'($urandom);
      smp.y = TILT_W'($urandom);
      return smp;
    end
    if (pick < 55) begin
      smp.x = sat16(int'($urandom_range(0, 2 * ONE_G)) - ONE_G);
      smp.y = sat16(int'($urandom_range(0, 2 * ONE_G)) - ONE_G);
      return smp;
    end
    if (pick < 75) begin
      // tan(22.5 deg) ~ 27146/65536
      m = $urandom_range(1, ONE_G);
      n = ((m * 27146) >>> 16) + jitter(2);
    end else begin
      r = (pick < 90) ? int'(dz) + jitter(2) : ONE_G + jitter(2);
      if (r < 0) r = 0;
      if ($urandom_range(0, 1)) begin
        m = r;
        n = jitter(1);
      end else begin
        // on the diagonal: r / sqrt(2) ~ r * 46341 / 65536
        m = (r * 46341) >>> 16;
        n = m + jitter(1);
      end
    end
    if ($urandom_range(0, 1)) m = -m;
    if ($urandom_range(0, 1)) n = -n;
    if ($urandom_range(0, 1)) begin
      smp.x = sat16(m);
      smp.y = sat16(n);
    end else begin
      smp.x = sat16(n);
      smp.y = sat16(m);
    end
    return smp;
  endfunction

  task automatic queue_tilt(input int x, input int y);
    tilt_sample_t smp;
    smp.x = sat16(x);
    smp.y = sat16(y);
    tilt_backlog.push_back(smp);
    n_queued++;
  endtask

  task automatic queue_random(input int count);
    repeat (count) begin
      tilt_backlog.push_back(random_tilt(dz_cfg));
      n_queued++;
    end
  endtask

  // Sender holds off until every queued sample has moved and every beat is back
  task automatic wait_drained();
    while (n_accepted != n_queued || drive_due.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // APB register access
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] want);
    logic [APB_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX)
        $display("[%0t] deadzone readback: expected %0d, got %0d", $realtime, want, got);
    end
  endtask

  // Only called with the pipe empty; upper data bits are ignored by the register
  task automatic set_deadzone(input logic [APB_DATA_W-1:0] data);
    apb_write(DEADZONE_ADDR, data);
    dz_cfg = data[DZ_W-1:0];
    n_settings++;
    apb_read_check(DEADZONE_ADDR, APB_DATA_W'(dz_cfg));
  endtask

  // ---------------------------------------------------------------------------
  // Sender: pops the backlog, holds each sample until taken, then idles for the
  // gap drawn with it. Calm stretches (no gaps) switch on and off at random.
  // ---------------------------------------------------------------------------
  int   src_gap  = 0;
  logic src_calm = 1'b0;

  always @(negedge clk) begin
    tilt_sample_t smp;
    if (rst) begin
      tilt_ch.valid  <= 1'b0;
      tilt_ch.tilt_x <= '0;
      tilt_ch.tilt_y <= '0;
      src_gap = 0;
    end else if (!tilt_ch.valid || tilt_took) begin
      if (src_gap != 0) begin
        tilt_ch.valid <= 1'b0;
        src_gap--;
      end else if (tilt_backlog.size() != 0) begin
        smp = tilt_backlog.pop_front();
        tilt_ch.valid  <= 1'b1;
        tilt_ch.tilt_x <= smp.x;
        tilt_ch.tilt_y <= smp.y;
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        src_gap = src_calm ? 0 : $urandom_range(0, 8);
      end else begin
        tilt_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each drive beat, ready drops for a drawn number of cycles
  // ---------------------------------------------------------------------------
  int   snk_hold = 0;
  logic snk_calm = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      drive_ch.ready <= 1'b0;
      snk_hold = 0;
    end else if (drive_took) begin
      if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
      snk_hold = snk_calm ? 0 : $urandom_range(0, 8);
      drive_ch.ready <= (snk_hold == 0);
    end else if (snk_hold != 0) begin
      drive_ch.ready <= (snk_hold == 1);
      snk_hold--;
    end else begin
      drive_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each tilt beat, check each drive beat against the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input drive_beat_t want,
                               input drive_beat_t got);
    mismatches++;
    if (mismatches <= SHOWN_MAX)
      $display("[%0t] %s: expected sec=%0d mag=%0d act=%0d, got sec=%0d mag=%0d act=%0d",
               $realtime, what, want.sector, want.magnitude, want.active,
               got.sector, got.magnitude, got.active);
  endtask

  always @(posedge clk) begin
    drive_beat_t want, got;
    tilt_took  <= !rst && tilt_ch.valid && tilt_ch.ready;
    drive_took <= !rst && drive_ch.valid && drive_ch.ready;
    if (!rst) begin
      if (tilt_ch.valid && tilt_ch.ready) begin
        drive_due.push_back(drive_from_tilt(tilt_ch.tilt_x, tilt_ch.tilt_y, dz_cfg));
        n_accepted++;
      end
      if (drive_ch.valid && drive_ch.ready) begin
        got.sector    = drive_ch.sector;
        got.magnitude = drive_ch.magnitude;
        got.active    = drive_ch.active;
        if (drive_due.size() == 0) begin
          note_mismatch("drive beat with nothing predicted", '0, got);
        end else begin
          want = drive_due.pop_front();
          n_checked++;
          if (want.active) n_active++;
          sectors_seen[want.sector] = 1'b1;
          if (got.sector !== want.sector || got.magnitude !== want.magnitude ||
              got.active !== want.active)
            note_mismatch("drive beat mismatch", want, got);
        end
      end
    end
  end

  // Watchdog: any beat on either channel counts as progress
  always @(posedge clk) begin
    if (rst || (tilt_ch.valid && tilt_ch.ready) || (drive_ch.valid && drive_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("Watchdog: %0d cycles with no beat, %0d predictions outstanding",
               idle_cycles, drive_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Register must come out of reset at its documented value
    apb_read_check(DEADZONE_ADDR, APB_DATA_W'(DZ_RESET));

    // Directed, at the reset deadzone
    queue_tilt(0, 0);                 // zero vector, inside deadzone
    queue_tilt(-32768, -32768);       // field extremes, all clamp
    queue_tilt(32767, 32767);
    queue_tilt(-32768, 32767);
    queue_tilt(32767, -32768);
    queue_tilt(-16384, 0);            // +side axis: sector 0
    queue_tilt(0, 16384);             // +fwd axis: sector 2
    queue_tilt(16384, 0);             // -side axis: sector 4
    queue_tilt(0, -16384);            // -fwd axis: sector 6
    queue_tilt(-16384, 16384);        // diagonals
    queue_tilt(16384, -16384);
    queue_tilt(-6786, 16384);         // straddling the 67.5 degree line
    queue_tilt(-6787, 16384);
    queue_tilt(-16384, 6786);         // straddling the 22.5 degree line
    queue_tilt(-16384, 6787);
    queue_tilt(-3276, 0);             // one short of the deadzone
    queue_tilt(-3277, 0);             // exactly on it
    queue_tilt(20000, 0);             // beyond 1 g, clamped
    queue_tilt(0, -20000);
    queue_tilt(21845, -21846);        // alternating bit patterns
    queue_tilt(-1, 0);
    queue_tilt(11585, 11585);         // just under full scale on a diagonal
    queue_tilt(11586, -11586);        // just over, saturates
    queue_random(150);
    wait_drained();
    queue_random(150);
    wait_drained();

    // Zero deadzone: the zero vector becomes active
    set_deadzone(0);
    queue_tilt(0, 0);
    queue_tilt(1, 0);
    queue_random(200);
    wait_drained();

    // Full scale deadzone, written with junk in the unused upper bits
    set_deadzone(32'habcd_4000);
    queue_random(150);
    wait_drained();

    // Deadzone above 1.0: nothing can be active
    set_deadzone(ONE_G + 1);
    queue_random(30);
    wait_drained();
    set_deadzone(32767);
    queue_random(40);
    wait_drained();

    set_deadzone(1);
    queue_random(100);
    wait_drained();

    repeat (4) begin
      set_deadzone($urandom_range(0, ONE_G));
      queue_random(150);
      wait_drained();
    end

    // Let any stray beat surface before the verdict
    repeat (24) @(negedge clk);

    $display("Summary: %0d tilt samples over %0d deadzone settings, %0d drive beats checked",
             n_accepted, n_settings, n_checked);
    $display("  %0d active, %0d in deadzone, sectors hit (7..0): %b",
             n_active, n_checked - n_active, sectors_seen);
    if (mismatches == 0 && drive_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
